// ===== sv/cpr_pkg.sv =====
// Shared constants and derived widths for the clock page replacement unit.
// Depends on nothing; imported by cpr_apb_regs, the top level and the checker.
package cpr_pkg;

  // Built frame count and the number of page bits kept from a request.
  localparam int FRAMES    = 8;
  localparam int PAGE_BITS = 16;

  // Fixed field widths of the stream and register ports.
  localparam int PAGE_W  = 16;
  localparam int FRAME_W = 3;
  localparam int TOTAL_W = 32;
  localparam int FU_W    = 4;

  // Frame index width and the width of a count that can hold FRAMES itself.
  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);

  // Result word: hit, frame, evicted_valid, evicted_page, fault_count, hit_count.
  localparam int RES_BITS = 1 + FRAME_W + 1 + PAGE_W + 2 * TOTAL_W;
  localparam int RES_W    = ((RES_BITS + 7) / 8) * 8;

  // Configuration port.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-1:0] REG_FRAMES_USED = 3'h0;

endpackage

// ===== sv/cpr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; used for the page tag store.
module cpr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/cpr_apb_regs.sv =====
// APB register slave holding frames_used, with the active frame count clamp.
// Depends on cpr_pkg.
module cpr_apb_regs import cpr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [CNT_W-1:0]  active_n
);

  logic [FU_W-1:0] frames_used;
  logic            wr_en;

  // Registers sit on word boundaries, so the low two address bits are ignored.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_FRAMES_USED[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_used <= FU_W'(FRAMES);
    end else if (wr_en) begin
      frames_used <= pwdata[FU_W-1:0];
    end
  end

  always_comb begin
    if (paddr[APB_AW-1:2] == REG_FRAMES_USED[APB_AW-1:2]) begin
      prdata = APB_DW'(frames_used);
    end else begin
      prdata = '0;
    end
  end

  // Zero behaves as one frame, anything above the built count as all frames.
  always_comb begin
    if (frames_used == '0) begin
      active_n = CNT_W'(1);
    end else if (32'(frames_used) > 32'(FRAMES)) begin
      active_n = CNT_W'(FRAMES);
    end else begin
      active_n = CNT_W'(frames_used);
    end
  end

endmodule

// ===== sv/clock_page_replacement_unit.sv =====
// Top level of the clock (second chance) page replacement unit.
// Depends on cpr_pkg, cpr_ram and cpr_apb_regs.
//
//   channel   role      handshake                 payload
//   s_*       request   s_tvalid / s_tready       s_tdata  = page
//   m_*       result    m_tvalid / m_tready       m_tdata  = hit .. hit_count
//   APB       config    psel, penable, pwrite     frames_used at byte address 0
//
// One request is in flight at a time. A hit is found by the single tag
// compare unit that walks the frames one per cycle through the tag RAM's
// registered read port. A miss runs that search over every active frame,
// then the one-frame-per-cycle hand sweep and then the victim's tag write.
// Reset is synchronous and clears the valid and reference bits, the hand and
// both totals; tag contents are only read behind a valid bit. A result waits
// in its output register for as long as m_tready stays low.
module clock_page_replacement_unit import cpr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // Request stream.
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,   // [15:0] page
  // Result stream.
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [RES_W-1:0]  m_tdata,   // [0] hit, [3:1] frame, [4] evicted_valid,
                                       // [20:5] evicted_page, [52:21] fault_count,
                                       // [84:53] hit_count, [87:85] zero
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_SWEEP  = 3'd2;
  localparam logic [2:0] ST_WRITE  = 3'd3;
  localparam logic [2:0] ST_OUT    = 3'd4;

  logic [2:0]           state;
  logic [CNT_W-1:0]     active_n;

  // Request and search pipeline.
  logic [PAGE_BITS-1:0] page_q;
  logic [CNT_W-1:0]     cnt;
  logic                 cmp_valid;
  logic [IDX_W-1:0]     cmp_idx;
  logic                 tag_match;

  // Frame state.
  logic [FRAMES-1:0]    valid;
  logic [FRAMES-1:0]    refb;
  logic [IDX_W-1:0]     hand;
  logic [IDX_W-1:0]     victim;
  logic [TOTAL_W-1:0]   faults;
  logic [TOTAL_W-1:0]   hits;

  // Tag RAM.
  logic [IDX_W-1:0]     rd_addr;
  logic [PAGE_BITS-1:0] rd_data;
  logic                 tag_we;

  // Result register.
  logic                 res_hit;
  logic [FRAME_W-1:0]   res_frame;
  logic                 res_evv;
  logic [PAGE_W-1:0]    res_evp;

  // Step a frame index forward, wrapping at the active count.
  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                               input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] nx;
    nx = CNT_W'(idx) + CNT_W'(1);
    return (nx >= n) ? '0 : IDX_W'(nx);
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
    return (v == '1) ? v : v + TOTAL_W'(1);
  endfunction

  cpr_apb_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .active_n (active_n)
  );

  // The read port is shared: frame by frame during the search, then the hand
  // position during the sweep so the victim's old tag is ready at the write.
  always_comb begin
    case (state)
      ST_SEARCH: rd_addr = cnt[IDX_W-1:0];
      ST_SWEEP:  rd_addr = hand;
      default:   rd_addr = victim;
    endcase
  end

  assign tag_we = (state == ST_WRITE);

  cpr_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (FRAMES)
  ) u_tags (
    .clk   (clk),
    .we    (tag_we),
    .waddr (victim),
    .wdata (page_q),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // The single compare unit: data read last cycle against the request.
  // Empty frames never match, so unwritten tags are never looked at.
  assign tag_match = cmp_valid && valid[cmp_idx] && (rd_data == page_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      cmp_valid <= 1'b0;
      valid     <= '0;
      refb      <= '0;
      hand      <= '0;
      faults    <= '0;
      hits      <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cnt       <= '0;
            cmp_valid <= 1'b0;
            state     <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          cmp_valid <= (cnt < active_n);
          if (cnt < active_n) begin
            cnt <= cnt + CNT_W'(1);
          end
          if (tag_match) begin
            refb[cmp_idx] <= 1'b1;
            hits          <= sat_inc(hits);
            state         <= ST_OUT;
          end else if (!cmp_valid && (cnt == active_n)) begin
            // No frame holds the page. A hand left outside a shrunken
            // frame range restarts at frame zero.
            if (CNT_W'(hand) >= active_n) begin
              hand <= '0;
            end
            state <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          if (!valid[hand] || !refb[hand]) begin
            state <= ST_WRITE;
          end else begin
            refb[hand] <= 1'b0;
            hand       <= advance(hand, active_n);
          end
        end
        ST_WRITE: begin
          valid[victim] <= 1'b1;
          refb[victim]  <= 1'b1;
          hand          <= advance(victim, active_n);
          faults        <= sat_inc(faults);
          state         <= ST_OUT;
        end
        ST_OUT: begin
          if (m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      page_q <= PAGE_BITS'(s_tdata);
    end
    if (state == ST_SEARCH) begin
      cmp_idx <= cnt[IDX_W-1:0];
      if (tag_match) begin
        res_hit   <= 1'b1;
        res_frame <= FRAME_W'(cmp_idx);
        res_evv   <= 1'b0;
        res_evp   <= '0;
      end
    end
    if (state == ST_SWEEP) begin
      victim <= hand;
    end
    if (state == ST_WRITE) begin
      res_hit   <= 1'b0;
      res_frame <= FRAME_W'(victim);
      res_evv   <= valid[victim];
      res_evp   <= valid[victim] ? PAGE_W'(rd_data) : '0;
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = RES_W'({hits, faults, res_evp, res_evv, res_frame, res_hit});

endmodule

// ===== sv/cpr_checker.sv =====
// Port-level checker for the clock page replacement unit, bound to the top.
// Depends on cpr_pkg and clock_page_replacement_unit.
module cpr_checker import cpr_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [RES_W-1:0] m_tdata
);

  // Only one request is ever in flight.
  a_busy_or_idle: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("request taken while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("ready stayed high after a request transaction");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready) |=> !m_tvalid)
    else $error("more than one result for a request");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // A hit never replaces a resident page.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> !m_tdata[4])
    else $error("eviction reported on a hit");

endmodule

bind clock_page_replacement_unit cpr_checker u_cpr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
